// File: rtl/core/vnhp_pkg.sv
// Package for the value-noise height perturbation unit.
// Holds register indexes, hash and blend constants and pipeline sizes; no dependencies.
package vnhp_pkg;

    localparam int MAX_GRID_DEF = 4096;
    localparam int LATENCY      = 14;

    localparam logic [2:0] REG_SEED      = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE = 3'd1;
    localparam logic [2:0] REG_FREQUENCY = 3'd2;
    localparam logic [2:0] REG_TILE      = 3'd3;
    localparam logic [2:0] REG_COLUMNS   = 3'd4;
    localparam logic [2:0] REG_ROWS      = 3'd5;

    localparam logic [1:0] KIND_HILL     = 2'd1;
    localparam logic [1:0] KIND_MOUNTAIN = 2'd2;

    localparam logic [31:0] HASH_KX     = 32'd73856093;
    localparam logic [31:0] HASH_KZ     = 32'd19349663;
    localparam logic [31:0] HASH_KS     = 32'd83492791;
    localparam logic [31:0] HASH_ADD    = 32'h9e3779b9;
    localparam logic [31:0] HASH_M1     = 32'hed5ad4bb;
    localparam logic [31:0] HASH_M2     = 32'hac4c1b51;
    localparam logic [31:0] HASH_M3     = 32'h31848bab;
    localparam logic [31:0] DETAIL_SALT = 32'hA21C9E37;

    localparam logic [31:0] FREQ_MIN   = 32'd1678;
    localparam logic [31:0] AMP_BYPASS = 32'd6;
    localparam logic [15:0] W_BASE     = 16'd42598;
    localparam logic [15:0] W_DETAIL   = 16'd22938;
    localparam logic [16:0] HILL_GAIN  = 17'd39322;

    localparam logic [31:0] RST_FREQUENCY = 32'd838861;
    localparam logic [31:0] RST_TILE      = 32'd65536;
    localparam logic [12:0] RST_GRID      = 13'd256;

    typedef struct packed {
        logic [11:0] column;
        logic [11:0] row;
        logic [1:0]  kind;
        logic [31:0] height;
        logic        pass;
    } item_t;

    typedef struct packed {
        logic [23:0] tx_base;
        logic [23:0] tz_base;
        logic [23:0] tx_detail;
        logic [23:0] tz_detail;
    } frac_t;

endpackage

// File: rtl/core/vnhp_hash.sv
// Lattice hash finisher: three multiply-xorshift rounds, one register each.
// Uses vnhp_pkg for the multiplier constants.
module vnhp_hash
    import vnhp_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] mix,
    output logic [23:0] lattice
);

    logic [31:0] m1_reg;
    logic [31:0] m2_reg;
    logic [31:0] m3_reg;
    logic [31:0] fin;

    always_ff @(posedge clk)
    begin
        m1_reg <= 32'((mix ^ (mix >> 17)) * HASH_M1);
        m2_reg <= 32'((m1_reg ^ (m1_reg >> 11)) * HASH_M2);
        m3_reg <= 32'((m2_reg ^ (m2_reg >> 15)) * HASH_M3);
    end

    assign fin     = m3_reg ^ (m3_reg >> 14);
    assign lattice = fin[23:0];

endmodule

// File: rtl/core/value_noise_height_perturb_unit.sv
// Top level of the two-octave value-noise height perturbation pipeline.
// Depends on vnhp_pkg and vnhp_hash.
//
// channel   ports                                       handshake
// config    cfg_we, cfg_index, cfg_data                 write when cfg_we high
// input     cell_column, cell_row, cell_kind, old_height start high, busy low
// result    out_column, out_row, new_height             done strobe, one cycle
//
// One item per cycle. The depth is set by the coordinate offset, multiply,
// recombine and lattice steps, the three hash multiply rounds, and the
// interpolation, weighting, scaling and clamp steps, one register each.
// busy is high during reset and until the first clock edge after it. Results
// cannot be held off, so the pipe never stalls.
module value_noise_height_perturb_unit
    import vnhp_pkg::*;
#(
    parameter int MAX_GRID = MAX_GRID_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] cell_column,
    input  logic [11:0] cell_row,
    input  logic [1:0]  cell_kind,
    input  logic [31:0] old_height,
    output logic        done,
    output logic [11:0] out_column,
    output logic [11:0] out_row,
    output logic [31:0] new_height
);

    localparam int GW  = $clog2(MAX_GRID + 1);
    localparam int D_W = ((GW > 13) ? GW : 13) + 1;
    localparam int P_W = D_W + 33;
    localparam int Q_W = P_W + 17;
    localparam int S_W = P_W + 33;

    // configuration
    logic [31:0] seed_reg;
    logic [31:0] amp_reg;
    logic [31:0] freq_reg;
    logic [31:0] tile_reg;
    logic [12:0] cols_reg;
    logic [12:0] rows_reg;
    logic        busy_reg;
    logic [31:0] seed_term_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= '0;
            amp_reg  <= '0;
            freq_reg <= RST_FREQUENCY;
            tile_reg <= RST_TILE;
            cols_reg <= RST_GRID;
            rows_reg <= RST_GRID;
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SEED:      seed_reg <= cfg_data;
                    REG_AMPLITUDE: amp_reg  <= cfg_data;
                    REG_FREQUENCY: freq_reg <= cfg_data;
                    REG_TILE:      tile_reg <= cfg_data;
                    REG_COLUMNS:   cols_reg <= cfg_data[12:0];
                    REG_ROWS:      rows_reg <= cfg_data[12:0];
                    default:       ;
                endcase
            end
        end
    end

    // seed contribution of the hash for both octaves, registered from the seed register
    always_ff @(posedge clk)
    begin
        seed_term_reg[0] <= 32'(seed_reg * HASH_KS) + HASH_ADD;
        seed_term_reg[1] <= 32'((seed_reg ^ DETAIL_SALT) * HASH_KS) + HASH_ADD;
    end

    assign busy = busy_reg;

    logic accept;
    assign accept = start && !busy_reg;

    // valid line and item payload line
    logic [LATENCY-1:0] valid_reg;
    item_t              item_reg [LATENCY];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LATENCY-2:0], accept};
        end
    end

    item_t item_in;
    always_comb
    begin
        item_in.column = cell_column;
        item_in.row    = cell_row;
        item_in.kind   = cell_kind;
        item_in.height = old_height;
        item_in.pass   = (amp_reg <= AMP_BYPASS) || (cell_kind == KIND_MOUNTAIN);
    end

    always_ff @(posedge clk)
    begin
        item_reg[0] <= item_in;
        for (int i = 1; i < LATENCY; i++)
        begin
            item_reg[i] <= item_reg[i-1];
        end
    end

    // stage 0: signed offset 2*index + 1 - grid
    logic [GW-1:0]         cols_c;
    logic [GW-1:0]         rows_c;
    logic signed [D_W-1:0] dx_reg;
    logic signed [D_W-1:0] dz_reg;

    assign cols_c = (32'(cols_reg) > 32'(MAX_GRID)) ? GW'(MAX_GRID) : GW'(cols_reg);
    assign rows_c = (32'(rows_reg) > 32'(MAX_GRID)) ? GW'(MAX_GRID) : GW'(rows_reg);

    always_ff @(posedge clk)
    begin
        dx_reg <= $signed({{(D_W-13){1'b0}}, cell_column, 1'b1})
                - $signed({{(D_W-GW){1'b0}}, cols_c});
        dz_reg <= $signed({{(D_W-13){1'b0}}, cell_row, 1'b1})
                - $signed({{(D_W-GW){1'b0}}, rows_c});
    end

    // stage 1: times tile size
    logic signed [P_W-1:0] px_reg;
    logic signed [P_W-1:0] pz_reg;

    always_ff @(posedge clk)
    begin
        px_reg <= P_W'(dx_reg * $signed({1'b0, tile_reg}));
        pz_reg <= P_W'(dz_reg * $signed({1'b0, tile_reg}));
    end

    // stage 2: times frequency, split into high and low halves
    logic [31:0]           freq_c;
    logic signed [Q_W-1:0] pxh_reg;
    logic signed [Q_W-1:0] pxl_reg;
    logic signed [Q_W-1:0] pzh_reg;
    logic signed [Q_W-1:0] pzl_reg;

    assign freq_c = (freq_reg < FREQ_MIN) ? FREQ_MIN : freq_reg;

    always_ff @(posedge clk)
    begin
        pxh_reg <= Q_W'(px_reg * $signed({1'b0, freq_c[31:16]}));
        pxl_reg <= Q_W'(px_reg * $signed({1'b0, freq_c[15:0]}));
        pzh_reg <= Q_W'(pz_reg * $signed({1'b0, freq_c[31:16]}));
        pzl_reg <= Q_W'(pz_reg * $signed({1'b0, freq_c[15:0]}));
    end

    // stage 3: recombine and floor to 24 fraction bits
    logic signed [S_W-1:0] sx_full;
    logic signed [S_W-1:0] sz_full;
    logic [55:0]           sx_reg;
    logic [55:0]           sz_reg;

    assign sx_full = ($signed({pxh_reg, 16'b0}) + S_W'(pxl_reg)) >>> 17;
    assign sz_full = ($signed({pzh_reg, 16'b0}) + S_W'(pzl_reg)) >>> 17;

    always_ff @(posedge clk)
    begin
        sx_reg <= sx_full[55:0];
        sz_reg <= sz_full[55:0];
    end

    // stage 4: lattice corner terms; detail octave samples at twice the point
    logic [31:0] hx_reg [2];
    logic [31:0] hz_reg [2];
    frac_t       frac_reg [4];
    frac_t       frac_in;

    always_comb
    begin
        frac_in.tx_base   = sx_reg[23:0];
        frac_in.tz_base   = sz_reg[23:0];
        frac_in.tx_detail = {sx_reg[22:0], 1'b0};
        frac_in.tz_detail = {sz_reg[22:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        hx_reg[0] <= 32'(sx_reg[55:24] * HASH_KX);
        hz_reg[0] <= 32'(sz_reg[55:24] * HASH_KZ);
        hx_reg[1] <= 32'(sx_reg[54:23] * HASH_KX);
        hz_reg[1] <= 32'(sz_reg[54:23] * HASH_KZ);
        frac_reg[0] <= frac_in;
        for (int i = 1; i < 4; i++)
        begin
            frac_reg[i] <= frac_reg[i-1];
        end
    end

    // stages 5-7: hash of the four corners of both octaves
    logic [23:0] lat [2][4];

    for (genvar o = 0; o < 2; o++)
    begin : g_oct
        for (genvar c = 0; c < 4; c++)
        begin : g_corner
            logic [31:0] hx_c;
            logic [31:0] hz_c;
            assign hx_c = (c % 2 == 1) ? hx_reg[o] + HASH_KX : hx_reg[o];
            assign hz_c = (c / 2 == 1) ? hz_reg[o] + HASH_KZ : hz_reg[o];
            vnhp_hash u_hash
            (
                .clk     (clk),
                .mix     (hx_c ^ hz_c ^ seed_term_reg[o]),
                .lattice (lat[o][c])
            );
        end
    end

    // stage 8: interpolate along x as n0 + (n1 - n0) * t
    logic [23:0]        tx8 [2];
    logic [23:0]        tz8 [2];
    logic [23:0]        n00_reg [2];
    logic [23:0]        n01_reg [2];
    logic [23:0]        tz_reg [2];
    logic signed [49:0] pa_reg [2];
    logic signed [49:0] pb_reg [2];

    assign tx8[0] = frac_reg[3].tx_base;
    assign tz8[0] = frac_reg[3].tz_base;
    assign tx8[1] = frac_reg[3].tx_detail;
    assign tz8[1] = frac_reg[3].tz_detail;

    always_ff @(posedge clk)
    begin
        for (int o = 0; o < 2; o++)
        begin
            n00_reg[o] <= lat[o][0];
            n01_reg[o] <= lat[o][2];
            tz_reg[o]  <= tz8[o];
            pa_reg[o]  <= 50'(($signed({1'b0, lat[o][1]}) - $signed({1'b0, lat[o][0]}))
                              * $signed({1'b0, tx8[o]}));
            pb_reg[o]  <= 50'(($signed({1'b0, lat[o][3]}) - $signed({1'b0, lat[o][2]}))
                              * $signed({1'b0, tx8[o]}));
        end
    end

    // stage 9: finish x pass, start z pass
    logic [23:0]        a_c [2];
    logic [23:0]        b_c [2];
    logic [23:0]        a_reg [2];
    logic signed [49:0] pz9_reg [2];
    logic signed [49:0] pa_s [2];
    logic signed [49:0] pb_s [2];

    always_comb
    begin
        for (int o = 0; o < 2; o++)
        begin
            pa_s[o] = pa_reg[o] >>> 24;
            pb_s[o] = pb_reg[o] >>> 24;
            a_c[o]  = n00_reg[o] + pa_s[o][23:0];
            b_c[o]  = n01_reg[o] + pb_s[o][23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int o = 0; o < 2; o++)
        begin
            a_reg[o]   <= a_c[o];
            pz9_reg[o] <= 50'(($signed({1'b0, b_c[o]}) - $signed({1'b0, a_c[o]}))
                              * $signed({1'b0, tz_reg[o]}));
        end
    end

    // stage 10: octave values, weighted
    logic [23:0]        noise_c [2];
    logic signed [49:0] pz_s [2];
    logic [39:0]        wb_reg;
    logic [39:0]        wd_reg;

    always_comb
    begin
        for (int o = 0; o < 2; o++)
        begin
            pz_s[o]    = pz9_reg[o] >>> 24;
            noise_c[o] = a_reg[o] + pz_s[o][23:0];
        end
    end

    always_ff @(posedge clk)
    begin
        wb_reg <= 40'(noise_c[0] * W_BASE);
        wd_reg <= 40'(noise_c[1] * W_DETAIL);
    end

    // stage 11: centre, double, floor to Q0.24 and scale by amplitude
    logic [40:0]        blend;
    logic signed [41:0] centred;
    logic signed [41:0] c24_full;
    logic signed [24:0] c24;
    logic signed [57:0] ap_reg;

    assign blend    = {1'b0, wb_reg} + {1'b0, wd_reg};
    assign centred  = $signed({1'b0, blend}) - $signed(42'(1) <<< 39);
    assign c24_full = centred >>> 15;
    assign c24      = c24_full[24:0];

    always_ff @(posedge clk)
    begin
        ap_reg <= 58'(c24 * $signed({1'b0, amp_reg}));
    end

    // stage 12: floor to Q16.16, hill gain product
    logic signed [57:0] ap_s;
    logic signed [33:0] pert_c;
    logic signed [33:0] pert_reg;
    logic signed [50:0] hill_reg;

    assign ap_s   = ap_reg >>> 24;
    assign pert_c = ap_s[33:0];

    always_ff @(posedge clk)
    begin
        pert_reg <= pert_c;
        hill_reg <= 51'(pert_c * $signed({1'b0, HILL_GAIN}));
    end

    // stage 13: add, clamp, select
    logic signed [50:0] hill_s;
    logic signed [33:0] adj;
    logic signed [35:0] sum;
    logic [31:0]        height_c;
    logic [31:0]        height_reg;
    item_t              last;

    assign last   = item_reg[LATENCY-2];
    assign hill_s = hill_reg >>> 16;
    assign adj    = (last.kind == KIND_HILL) ? hill_s[33:0] : pert_reg;
    assign sum    = $signed({4'b0, last.height}) + 36'(adj);

    always_comb
    begin
        if (last.pass)
            height_c = last.height;
        else if (sum < 0)
            height_c = '0;
        else if (sum > $signed({4'b0, 32'hFFFFFFFF}))
            height_c = 32'hFFFFFFFF;
        else
            height_c = sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        height_reg <= height_c;
    end

    assign done       = valid_reg[LATENCY-1];
    assign out_column = item_reg[LATENCY-1].column;
    assign out_row    = item_reg[LATENCY-1].row;
    assign new_height = height_reg;

endmodule

// File: rtl/core/vnhp_checker.sv
// Port-level checks for value_noise_height_perturb_unit, bound to the top level.
// Uses vnhp_pkg for latency and terrain codes.
module vnhp_checker
    import vnhp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [11:0] cell_column,
    input logic [1:0]  cell_kind,
    input logic [31:0] old_height,
    input logic        done,
    input logic [11:0] out_column,
    input logic [31:0] new_height
);

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("item taken without a result at fixed latency");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching item");

    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> out_column == $past(cell_column, LATENCY))
        else $error("column echo mismatch");

    a_mountain: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(cell_kind == KIND_MOUNTAIN, LATENCY)
            |-> new_height == $past(old_height, LATENCY))
        else $error("mountain height changed");

endmodule

bind value_noise_height_perturb_unit vnhp_checker u_vnhp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cell_column (cell_column),
    .cell_kind   (cell_kind),
    .old_height  (old_height),
    .done        (done),
    .out_column  (out_column),
    .new_height  (new_height)
);
